FILE: rtl/core/prs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_pkg
// Shared types, constants and the name normalizing function of the pending
// recipient set.
// ----------------------------------------------------------------------------
package prs_pkg;

   // Geometry
   localparam int SLOTS      = 256;
   localparam int NAME_BYTES = 8;
   localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int NS_W       = 32;
   localparam int NAME_W     = 64;

   // Request codes
   typedef enum logic [1:0] {
      REQ_ADD   = 2'd0,
      REQ_CLEAR = 2'd1,
      REQ_ANY   = 2'd2,
      REQ_MAYBE = 2'd3
   } req_kind_type;

   // Input beat
   typedef struct packed {
      req_kind_type      req_type;
      logic [NS_W-1:0]   ns_id;
      logic [NAME_W-1:0] user_name;
   } req_item_type;

   // Result beat
   typedef struct packed {
      logic answer;
      logic slot_taken;
      logic overflow;
   } rsp_item_type;

   // Controller to datapath
   typedef struct packed {
      logic load;    // capture request
      logic step;    // read next slot
      logic commit;  // finish request, emit result
   } prs_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic quick;     // answer known without a scan
      logic last_rd;   // read address is at the last slot
   } prs_status_type;

   // Truncate at first zero byte or NAME_BYTES, fold A-Z to a-z
   function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] raw);
      logic [NAME_W-1:0] r;
      logic              stop;
      logic [7:0]        b;
      r    = '0;
      stop = 1'b0;
      for (int i = 0; i < 8; i++) begin
         b = raw[8*i +: 8];
         if (b == 8'h00 || i >= NAME_BYTES) begin
            stop = 1'b1;
         end
         if (!stop) begin
            if (b >= 8'h41 && b <= 8'h5A) begin
               b = b + 8'h20;
            end
            r[8*i +: 8] = b;
         end
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/pending_recipient_set.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pending_recipient_set
// Bounded set of (namespace, user name) pairs with an overflow flag.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat (req_item: req_type, ns_id, user_name) is taken when
//   start is high and busy is low. Every request gives one result beat on
//   rsp_item, marked by rsp_valid for a single cycle; the receiver cannot
//   stall, so it must take the beat in that cycle.
//   Requests answered without a scan (an empty name on add, clear or maybe,
//   or any/maybe while overflow is set) go from the check state to commit.
//   All others scan the slot memory one slot per cycle through its single
//   registered read port, then take the last compare before the commit.
//   One request is in flight at a time; a new one may be accepted in the
//   cycle the result strobe is shown.
//   Reset clears all valid bits and the overflow flag at once; no clearing
//   pass is needed, the slot contents are only read behind a valid bit.
// ----------------------------------------------------------------------------
module pending_recipient_set (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  prs_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   output prs_pkg::rsp_item_type rsp_item
);

   prs_pkg::prs_cmd_type    cmd;
   prs_pkg::prs_status_type status;

   prs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   prs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

FILE: rtl/core/prs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_ctrl
// Sequencer: accepts a request, runs the slot scan unless the answer is known without one, then commits the result.
// ----------------------------------------------------------------------------
module prs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  prs_pkg::prs_status_type status,
   output prs_pkg::prs_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHECK  = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_LAST   = 5'b01000,
      ST_COMMIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.step   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = status.quick ? ST_COMMIT : ST_SCAN;
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            if (status.last_rd) begin
               state_in = ST_LAST;
            end
         end
         // last compare lands here
         ST_LAST: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: rtl/core/prs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_datapath
// Slot memory, valid bits, overflow flag, compare stage and result register.
// ----------------------------------------------------------------------------
module prs_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  prs_pkg::req_item_type    req_item,
   input  prs_pkg::prs_cmd_type     cmd,
   output prs_pkg::prs_status_type  status,
   output logic                     rsp_valid,
   output prs_pkg::rsp_item_type    rsp_item
);

   localparam int SW  = prs_pkg::SLOT_W;
   localparam int NSW = prs_pkg::NS_W;
   localparam int NMW = prs_pkg::NAME_W;

   // Request registers
   prs_pkg::req_kind_type kind_ff;
   logic [NSW-1:0]        ns_ff;
   logic [NMW-1:0]        name_ff;

   // Slot store
   logic [NSW+NMW-1:0]    mem [prs_pkg::SLOTS];
   logic [NSW+NMW-1:0]    rd_data_ff;
   logic [prs_pkg::SLOTS-1:0] valid_ff, valid_in;
   logic                  overflow_ff, overflow_in;

   // Scan pipeline
   logic [SW-1:0]         rd_idx_ff, rd_idx_in;
   logic                  cmp_vld_ff;
   logic [SW-1:0]         cmp_idx_ff;

   // Scan results
   logic                  hit_ff, hit_in;
   logic                  have_free_ff, have_free_in;
   logic [SW-1:0]         free_idx_ff, free_idx_in;
   logic                  not_empty_ff, not_empty_in;

   // Result register
   logic                  rsp_valid_ff;
   prs_pkg::rsp_item_type rsp_ff, rsp_in;
   logic                  wr_en;

   logic                  slot_v, ns_eq, name_eq, name_zero;

   assign name_zero = (name_ff == '0);
   assign slot_v    = valid_ff[cmp_idx_ff];
   assign ns_eq     = (rd_data_ff[NSW+NMW-1:NMW] == ns_ff);
   assign name_eq   = (rd_data_ff[NMW-1:0] == name_ff);

   // Status to controller
   always_comb begin
      status.quick   = ((kind_ff == prs_pkg::REQ_ANY) && overflow_ff) ||
                       ((kind_ff == prs_pkg::REQ_MAYBE) && overflow_ff) ||
                       ((kind_ff != prs_pkg::REQ_ANY) && name_zero);
      status.last_rd = (rd_idx_ff == SW'(prs_pkg::SLOTS - 1));
   end

   // Compare stage, result commit
   always_comb begin
      hit_in       = hit_ff;
      have_free_in = have_free_ff;
      free_idx_in  = free_idx_ff;
      not_empty_in = not_empty_ff;
      valid_in     = valid_ff;
      overflow_in  = overflow_ff;
      rd_idx_in    = rd_idx_ff;
      wr_en        = 1'b0;
      rsp_in       = rsp_ff;

      if (cmd.step) begin
         rd_idx_in = rd_idx_ff + SW'(1);
      end

      if (cmp_vld_ff) begin
         case (kind_ff)
            prs_pkg::REQ_ANY: begin
               if (slot_v && ns_eq) hit_in = 1'b1;
            end
            prs_pkg::REQ_ADD: begin
               if (slot_v && ns_eq && name_eq) begin
                  hit_in = 1'b1;
               end else if (!slot_v && !have_free_ff) begin
                  have_free_in = 1'b1;
                  free_idx_in  = cmp_idx_ff;
               end
            end
            prs_pkg::REQ_CLEAR: begin
               if (slot_v) begin
                  if (ns_eq && name_eq) begin
                     valid_in[cmp_idx_ff] = 1'b0;
                     hit_in               = 1'b1;
                  end else begin
                     not_empty_in = 1'b1;
                  end
               end
            end
            default: begin
               if (slot_v && ns_eq && name_eq) hit_in = 1'b1;
            end
         endcase
      end

      if (cmd.load) begin
         hit_in       = 1'b0;
         have_free_in = 1'b0;
         free_idx_in  = '0;
         not_empty_in = 1'b0;
         rd_idx_in    = '0;
      end

      if (cmd.commit) begin
         rsp_in.slot_taken = 1'b0;
         if (status.quick) begin
            rsp_in.answer = overflow_ff && !name_zero && (kind_ff == prs_pkg::REQ_MAYBE) ||
                            overflow_ff && (kind_ff == prs_pkg::REQ_ANY);
         end else begin
            rsp_in.answer = hit_ff;
            if (kind_ff == prs_pkg::REQ_ADD && !hit_ff) begin
               if (have_free_ff) begin
                  wr_en                 = 1'b1;
                  valid_in[free_idx_ff] = 1'b1;
                  rsp_in.slot_taken     = 1'b1;
               end else begin
                  overflow_in = 1'b1;
               end
            end
            if (kind_ff == prs_pkg::REQ_CLEAR && !not_empty_ff) begin
               overflow_in = 1'b0;
            end
         end
         rsp_in.overflow = overflow_in;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         overflow_ff  <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         overflow_ff  <= overflow_in;
         cmp_vld_ff   <= cmd.step;
         rsp_valid_ff <= cmd.commit;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_item.req_type;
         ns_ff   <= req_item.ns_id;
         name_ff <= prs_pkg::norm_name(req_item.user_name);
      end
      cmp_idx_ff   <= rd_idx_ff;
      rd_idx_ff    <= rd_idx_in;
      hit_ff       <= hit_in;
      have_free_ff <= have_free_in;
      free_idx_ff  <= free_idx_in;
      not_empty_ff <= not_empty_in;
      rsp_ff       <= rsp_in;
   end

   // Slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[free_idx_ff] <= {ns_ff, name_ff};
      end
      rd_data_ff <= mem[rd_idx_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

FILE: rtl/core/prs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_checker
// Port level checks of the pending recipient set, bound to the top level.
// ----------------------------------------------------------------------------
module prs_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input prs_pkg::rsp_item_type rsp_item
);

   // accepted beat makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accept did not raise busy");

   // result strobe only after a busy cycle, never while busy
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) && !busy)
      else $error("result strobe outside a request");

   // strobe lasts one cycle
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // a fresh slot is never taken for a pair already present
   a_taken_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.slot_taken |-> !rsp_item.answer)
      else $error("slot taken for present pair");

endmodule

bind pending_recipient_set prs_checker u_prs_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

FILE: tb/pending_recipient_set_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pending_recipient_set_tb
// Self-checking bench for the pending recipient set. Requests are driven
// through the start/busy handshake. A local model of the slot table and
// overflow flag predicts every result beat, and a monitor compares each
// strobed result field by field, in order. Stimulus runs a directed pass
// (folding, terminators, empty names), a fill to overflow and back, and
// random rounds over small and large pools of pairs with some noise.
// ----------------------------------------------------------------------------
module pending_recipient_set_tb;
   import prs_pkg::*;

   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = SLOTS + 8;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_valid;
   rsp_item_type rsp_item;

   // Local copy of the slot table
   bit                held[SLOTS];
   logic [NS_W-1:0]   held_ns[SLOTS];
   logic [NAME_W-1:0] held_name[SLOTS];
   bit                spill;

   rsp_item_type pending_answers[$];
   int           mismatch_count = 0;
   int           quiet_cycles   = 0;
   bit           idle_on        = 1'b1;

   pending_recipient_set dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Cut at the first zero byte, fold upper case letters
   function automatic logic [NAME_W-1:0] fold_name(input logic [NAME_W-1:0] raw);
      logic [NAME_W-1:0] folded;
      logic [7:0]        ch;
      int                k;
      folded = '0;
      k      = 0;
      while (k < NAME_BYTES && k < 8 && raw[8*k +: 8] != 8'h00) begin
         ch = raw[8*k +: 8];
         if (ch >= 8'h41 && ch <= 8'h5A) begin
            ch = ch + 8'h20;
         end
         folded[8*k +: 8] = ch;
         k++;
      end
      return folded;
   endfunction

   // Apply one request to the local table and return the result it gives
   function automatic rsp_item_type predict_set_request(input req_item_type beat);
      rsp_item_type      res;
      logic [NAME_W-1:0] name;
      bit                hit;
      bit                taken;
      bit                free_found;
      bit                others;
      int                free_idx;
      name       = fold_name(beat.user_name);
      hit        = 1'b0;
      taken      = 1'b0;
      free_found = 1'b0;
      others     = 1'b0;
      free_idx   = 0;
      if (beat.req_type == REQ_ANY) begin
         if (spill) begin
            hit = 1'b1;
         end else begin
            for (int i = 0; i < SLOTS; i++) begin
               if (held[i] && held_ns[i] == beat.ns_id) hit = 1'b1;
            end
         end
      end else if (name != '0) begin
         case (beat.req_type)
            REQ_ADD: begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (held[i] && held_ns[i] == beat.ns_id && held_name[i] == name) begin
                     hit = 1'b1;
                  end else if (!held[i] && !free_found) begin
                     free_found = 1'b1;
                     free_idx   = i;
                  end
               end
               if (!hit && free_found) begin
                  held[free_idx]      = 1'b1;
                  held_ns[free_idx]   = beat.ns_id;
                  held_name[free_idx] = name;
                  taken               = 1'b1;
               end else if (!hit) begin
                  spill = 1'b1;
               end
            end
            REQ_CLEAR: begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (held[i]) begin
                     if (held_ns[i] == beat.ns_id && held_name[i] == name) begin
                        held[i] = 1'b0;
                        hit     = 1'b1;
                     end else begin
                        others = 1'b1;
                     end
                  end
               end
               // set left empty: fallback no longer needed
               if (!others) spill = 1'b0;
            end
            default: begin
               if (spill) begin
                  hit = 1'b1;
               end else begin
                  for (int i = 0; i < SLOTS; i++) begin
                     if (held[i] && held_ns[i] == beat.ns_id && held_name[i] == name) begin
                        hit = 1'b1;
                     end
                  end
               end
            end
         endcase
      end
      res.answer     = hit;
      res.slot_taken = taken;
      res.overflow   = spill;
      return res;
   endfunction

   function automatic int held_total();
      int n;
      n = 0;
      for (int i = 0; i < SLOTS; i++) n += held[i];
      return n;
   endfunction

   function automatic logic [NAME_W-1:0] ascii_name(input string s);
      logic [NAME_W-1:0] n;
      n = '0;
      for (int i = 0; i < s.len() && i < 8; i++) n[8*i +: 8] = s[i];
      return n;
   endfunction

   // Random name of len nonzero bytes, half of them letters of either case
   function automatic logic [NAME_W-1:0] make_name(input int len);
      logic [NAME_W-1:0] n;
      logic [7:0]        ch;
      n = '0;
      for (int i = 0; i < len && i < 8; i++) begin
         if ($urandom_range(1) == 1) begin
            ch = 8'($urandom_range(8'h41, 8'h5A));
            if ($urandom_range(1) == 1) ch = ch | 8'h20;
         end else begin
            ch = 8'($urandom_range(1, 255));
         end
         n[8*i +: 8] = ch;
      end
      return n;
   endfunction

   // Same pair, other spelling: flip letter case, junk after the terminator
   function automatic logic [NAME_W-1:0] vary_name(input logic [NAME_W-1:0] raw);
      logic [NAME_W-1:0] v;
      logic [7:0]        ch;
      bit                ended;
      v     = raw;
      ended = 1'b0;
      for (int i = 0; i < 8; i++) begin
         ch = v[8*i +: 8];
         if (ended || i >= NAME_BYTES) begin
            if ($urandom_range(1) == 1) v[8*i +: 8] = 8'($urandom_range(255));
         end else if (ch == 8'h00) begin
            ended = 1'b1;
         end else if ((ch | 8'h20) >= 8'h61 && (ch | 8'h20) <= 8'h7A
                      && $urandom_range(1) == 1) begin
            v[8*i +: 8] = ch ^ 8'h20;
         end
      end
      return v;
   endfunction

   // Send one request beat; start stays high after the beat is taken
   task automatic send_req(input req_kind_type kind, input logic [NS_W-1:0] ns,
                           input logic [NAME_W-1:0] name);
      req_item_type beat;
      int           gap;
      beat.req_type  = kind;
      beat.ns_id     = ns;
      beat.user_name = name;
      gap            = 0;
      if (idle_on && $urandom_range(99) < 17) begin
         // mostly short holes, now and then one long enough to land mid scan
         gap = ($urandom_range(7) == 0) ? $urandom_range(1, SLOTS + 12)
                                        : $urandom_range(1, 4);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= beat;
      do @(posedge clock); while (busy);
      pending_answers.push_back(predict_set_request(beat));
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic clear_everything();
      logic [NS_W-1:0]   ns_q[$];
      logic [NAME_W-1:0] name_q[$];
      for (int i = 0; i < SLOTS; i++) begin
         if (held[i]) begin
            ns_q.push_back(held_ns[i]);
            name_q.push_back(held_name[i]);
         end
      end
      foreach (ns_q[k]) send_req(REQ_CLEAR, ns_q[k], vary_name(name_q[k]));
   endtask

   task automatic test_directed();
      send_req(REQ_ANY,   32'h0, '0);
      send_req(REQ_MAYBE, 32'h0, ascii_name("a"));
      send_req(REQ_ADD,   32'h0, ascii_name("a"));
      send_req(REQ_ADD,   32'h0, ascii_name("A"));            // folded duplicate
      send_req(REQ_ADD,   32'hFFFF_FFFF, '1);                 // eight 0xFF bytes
      send_req(REQ_MAYBE, 32'hFFFF_FFFF, '1);
      send_req(REQ_MAYBE, 32'hFFFF_FFFE, '1);
      send_req(REQ_MAYBE, 32'h0, 64'hDEAD_BEEF_0000_0041);    // junk after terminator
      // empty names change nothing
      send_req(REQ_ADD,   32'h0, 64'hFFFF_FFFF_FFFF_FF00);
      send_req(REQ_CLEAR, 32'h0, 64'h0000_0000_0000_FF00);
      send_req(REQ_MAYBE, 32'hFFFF_FFFF, 64'h1234_0000_0000_0000);
      // any ignores the name
      send_req(REQ_ANY,   32'h0, '1);
      send_req(REQ_ANY,   32'h1, '0);
      // '@' and '[' sit just outside A-Z and must not fold
      send_req(REQ_ADD,   32'h5, 64'h7B60_5B40);
      send_req(REQ_MAYBE, 32'h5, 64'h7B60_5B60);
      send_req(REQ_MAYBE, 32'h5, 64'h7B60_7B40);
      send_req(REQ_ADD,   32'h5, ascii_name("MiXeD zZ"));
      send_req(REQ_MAYBE, 32'h5, ascii_name("mixed Zz"));
      send_req(REQ_CLEAR, 32'h0, ascii_name("a"));
      send_req(REQ_CLEAR, 32'h0, ascii_name("A"));
      send_req(REQ_ANY,   32'h0, '0);
      clear_everything();
      send_req(REQ_CLEAR, 32'h7, ascii_name("x"));            // clear on empty set
   endtask

   task automatic test_fill_overflow();
      idle_on = 1'b0;
      while (held_total() < SLOTS) begin
         send_req(REQ_ADD, $urandom_range(15), make_name($urandom_range(1, NAME_BYTES)));
      end
      send_req(REQ_ADD,   32'h100, ascii_name("spill"));      // no free slot
      send_req(REQ_ADD,   held_ns[SLOTS-1], vary_name(held_name[SLOTS-1]));
      send_req(REQ_ANY,   32'hABCD_0000, '0);
      send_req(REQ_MAYBE, 32'h100, ascii_name("spill"));
      send_req(REQ_MAYBE, 32'h100, '0);
      send_req(REQ_ADD,   32'h100, '0);
      send_req(REQ_CLEAR, 32'h100, ascii_name("spill"));      // no match, flag holds
      send_req(REQ_CLEAR, held_ns[SLOTS/2], vary_name(held_name[SLOTS/2]));
      send_req(REQ_ADD,   32'h100, ascii_name("SPILL"));      // reuses the hole
      idle_on = 1'b1;
      clear_everything();
      send_req(REQ_ANY,   32'h100, '0);
   endtask

   task automatic test_random_mix(input int beats, input int names_n, input int ns_n,
                                  input int add_pct, input int prefill);
      logic [NS_W-1:0]   ns_pool[$];
      logic [NAME_W-1:0] name_pool[$];
      req_kind_type      kind;
      logic [NS_W-1:0]   ns;
      logic [NAME_W-1:0] name;
      ns_pool.push_back(32'h0);
      ns_pool.push_back(32'hFFFF_FFFF);
      while (ns_pool.size() < ns_n) ns_pool.push_back($urandom);
      repeat (names_n) name_pool.push_back(make_name($urandom_range(1, NAME_BYTES)));
      while (held_total() < prefill) begin
         send_req(REQ_ADD, ns_pool[$urandom_range(ns_pool.size() - 1)],
                  vary_name(name_pool[$urandom_range(name_pool.size() - 1)]));
      end
      repeat (beats) begin
         if ($urandom_range(99) < 15) begin
            // noise over the full field ranges
            kind = req_kind_type'(2'($urandom_range(3)));
            ns   = $urandom;
            name = {$urandom, $urandom};
            if ($urandom_range(3) == 0) name[7:0] = 8'h00;
         end else begin
            if ($urandom_range(99) < add_pct) begin
               kind = REQ_ADD;
            end else begin
               case ($urandom_range(2))
                  0:       kind = REQ_CLEAR;
                  1:       kind = REQ_ANY;
                  default: kind = REQ_MAYBE;
               endcase
            end
            ns   = ns_pool[$urandom_range(ns_pool.size() - 1)];
            name = vary_name(name_pool[$urandom_range(name_pool.size() - 1)]);
         end
         send_req(kind, ns, name);
      end
      clear_everything();
   endtask

   task automatic note_mismatch(input string what, input rsp_item_type want,
                                input rsp_item_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("[%0t] %s: expected answer=%0b taken=%0b overflow=%0b,", $realtime, what,
                  want.answer, want.slot_taken, want.overflow);
         $display("        got answer=%0b taken=%0b overflow=%0b",
                  got.answer, got.slot_taken, got.overflow);
      end
   endtask

   // Result monitor: each strobed beat against the oldest prediction
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            note_mismatch("result beat with nothing outstanding", '0, rsp_item);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_item.answer !== want.answer || rsp_item.slot_taken !== want.slot_taken
                || rsp_item.overflow !== want.overflow) begin
               note_mismatch("result mismatch", want, rsp_item);
            end
         end
      end
   end

   // Watchdog on cycles without any accepted beat or result strobe
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_fill_overflow();
      test_random_mix(300, 10, 4, 40, 0);
      test_random_mix(200, 64, 8, 50, SLOTS - 16);
      test_random_mix(200, 6, 3, 30, 0);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_answers.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/prs_pkg.sv
rtl/core/prs_ctrl.sv
rtl/core/prs_datapath.sv
rtl/core/pending_recipient_set.sv
rtl/core/prs_checker.sv
tb/pending_recipient_set_tb.sv
